### src/sfd_pkg.sv
// Shared constants, types and register codes for the SBUS frame channel decoder.
`default_nettype none
package sfd_pkg;

  localparam int PAYLOAD_BYTES = 24;
  localparam int STORE_DEPTH   = 24;
  localparam int CHANNEL_BYTES = 22;
  localparam int NUM_CHANNELS  = 16;
  localparam int CH_BITS       = 11;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);
  localparam int PTR_W         = $clog2(CHANNEL_BYTES + 1);
  localparam int IDX_W         = $clog2(NUM_CHANNELS);
  localparam int ACC_W         = CH_BITS - 1 + 8;
  localparam int NBITS_W       = $clog2(ACC_W + 1);
  localparam int CFG_W         = 11;

  localparam logic [7:0]         HEADER_RST   = 8'h0f;
  localparam logic [CH_BITS-1:0] DEADBAND_RST = 11'd15;
  localparam logic [CH_BITS-1:0] SW_HIGH_RST  = 11'd1600;
  localparam logic [CH_BITS-1:0] SW_LOW_RST   = 11'd400;
  localparam logic [CH_BITS:0]   CENTRE       = 12'd1024;

  localparam logic [CH_BITS-1:0] SW_POS_UP   = 11'd1;
  localparam logic [CH_BITS-1:0] SW_POS_MID  = 11'd2;
  localparam logic [CH_BITS-1:0] SW_POS_DOWN = 11'd3;

  typedef enum logic [1:0] {
    REG_HEADER   = 2'd0,
    REG_DEADBAND = 2'd1,
    REG_SW_HIGH  = 2'd2,
    REG_SW_LOW   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]         header;
    logic [CH_BITS-1:0] deadband;
    logic [CH_BITS-1:0] sw_high;
    logic [CH_BITS-1:0] sw_low;
  } cfg_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

  typedef struct packed {
    logic             busy;
    logic [PTR_W-1:0] rd_ptr;
  } unpack_stat_t;

endpackage
`default_nettype wire

### src/sfd_if.sv
// Word channel interfaces: received bytes in, decoded channels out.
`default_nettype none
interface sfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         channel_index;
  logic signed [10:0] channel_value;
  logic               last_of_frame;
  modport source (output valid, output channel_index, output channel_value,
                  output last_of_frame, input ready);
  modport sink   (input valid, input channel_index, input channel_value,
                  input last_of_frame, output ready);
endinterface
`default_nettype wire

### src/sfd_store.sv
// Frame byte store: one write port, one registered read port.
`default_nettype none
module sfd_store
  import sfd_pkg::*;
(
  input  wire logic              clk,
  input  wire store_wr_t         wr,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]             rd_data
);

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

### src/sfd_capture.sv
// Header hunt and byte collection into the frame store, with write interlock.
`default_nettype none
module sfd_capture
  import sfd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  sfd_in_if.sink            in_ch,
  input  wire logic [7:0]   header,
  input  wire unpack_stat_t stat,
  output store_wr_t         wr,
  output logic              start
);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PAYLOAD_BYTES - 1);

  logic              in_frame_r, in_frame_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic              accept;
  logic              is_last;

  assign is_last = (cnt_r == LAST_ADDR);

  // while unpacking, only overwrite entries already read and never close a frame
  assign in_ch.ready = !stat.busy || !in_frame_r ||
                       ((PTR_W'(cnt_r) < stat.rd_ptr) && !is_last);
  assign accept = in_ch.valid && in_ch.ready;

  always_comb begin
    in_frame_nxt = in_frame_r;
    cnt_nxt      = cnt_r;
    start        = 1'b0;
    wr.en        = 1'b0;
    wr.addr      = cnt_r;
    wr.data      = in_ch.rx_byte;
    if (accept) begin
      if (!in_frame_r) begin
        if (in_ch.rx_byte == header) begin
          in_frame_nxt = 1'b1;
          cnt_nxt      = '0;
        end
      end else begin
        wr.en = 1'b1;
        if (is_last) begin
          in_frame_nxt = 1'b0;
          cnt_nxt      = '0;
          start        = 1'b1;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

### src/sfd_unpack.sv
// Bit-stream unpacker: reads stored bytes, cuts 11-bit channels, decodes them.
`default_nettype none
module sfd_unpack
  import sfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire cfg_t        cfg,
  input  wire logic [7:0]  rd_data,
  output logic             rd_en,
  output logic [ADDR_W-1:0] rd_addr,
  output unpack_stat_t     stat,
  sfd_out_if.source        out_ch
);

  logic               busy_r, busy_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic               pend_r, pend_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [NBITS_W-1:0] nbits_r, nbits_nxt;
  logic [IDX_W-1:0]   ch_r, ch_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]   out_idx_r;
  logic [CH_BITS-1:0] out_val_r, dec_val;
  logic               out_last_r;
  logic               slot_free, issue, emit, have_ch;
  logic [CH_BITS-1:0] raw;
  logic [CH_BITS:0]   cen;
  logic [CH_BITS-1:0] mag;

  assign have_ch   = (nbits_r >= NBITS_W'(CH_BITS));
  assign slot_free = !out_valid_r || out_ch.ready;
  assign issue     = busy_r && !pend_r && !have_ch && (rd_ptr_r < PTR_W'(CHANNEL_BYTES));
  assign emit      = busy_r && !pend_r && have_ch && slot_free;

  assign rd_en   = issue;
  assign rd_addr = rd_ptr_r[ADDR_W-1:0];
  assign stat.busy   = busy_r;
  assign stat.rd_ptr = rd_ptr_r;

  // channel decode
  assign raw = acc_r[CH_BITS-1:0];
  assign cen = {1'b0, raw} - CENTRE;
  assign mag = cen[CH_BITS] ? CH_BITS'(-cen) : cen[CH_BITS-1:0];

  always_comb begin
    if (ch_r inside {[4'd4:4'd11]}) begin
      if (raw > cfg.sw_high) begin
        dec_val = SW_POS_UP;
      end else if (raw < cfg.sw_low) begin
        dec_val = SW_POS_DOWN;
      end else begin
        dec_val = SW_POS_MID;
      end
    end else if (ch_r < 4'd4 && mag < cfg.deadband) begin
      dec_val = '0;
    end else begin
      dec_val = cen[CH_BITS-1:0];
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    rd_ptr_nxt    = rd_ptr_r;
    pend_nxt      = issue;
    acc_nxt       = acc_r;
    nbits_nxt     = nbits_r;
    ch_nxt        = ch_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (issue) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (pend_r) begin
      acc_nxt   = acc_r | (ACC_W'(rd_data) << nbits_r);
      nbits_nxt = nbits_r + NBITS_W'(8);
    end
    if (emit) begin
      acc_nxt       = acc_r >> CH_BITS;
      nbits_nxt     = nbits_r - NBITS_W'(CH_BITS);
      ch_nxt        = ch_r + 1'b1;
      out_valid_nxt = 1'b1;
      if (ch_r == IDX_W'(NUM_CHANNELS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
    if (start) begin
      busy_nxt   = 1'b1;
      rd_ptr_nxt = '0;
      pend_nxt   = 1'b0;
      acc_nxt    = '0;
      nbits_nxt  = '0;
      ch_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      rd_ptr_r    <= '0;
      pend_r      <= 1'b0;
      nbits_r     <= '0;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      pend_r      <= pend_nxt;
      nbits_r     <= nbits_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (emit) begin
      out_idx_r  <= ch_r;
      out_val_r  <= dec_val;
      out_last_r <= (ch_r == IDX_W'(NUM_CHANNELS - 1));
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.channel_index = out_idx_r;
  assign out_ch.channel_value = $signed(out_val_r);
  assign out_ch.last_of_frame = out_last_r;

endmodule
`default_nettype wire

### src/sbus_frame_channel_decoder.sv
// Top level: configuration registers, capture, frame store and unpacker.
//
//  channel  dir  word                                           handshake
//  in_ch    in   rx_byte[7:0]                                   valid/ready
//  out_ch   out  channel_index[3:0], channel_value[10:0] s,     valid/ready
//                last_of_frame
//  cfg      in   cfg_we, cfg_index[1:0], cfg_wdata[10:0]        write enable
//
// One received byte per cycle while in_ch.ready is high. The closing byte of a frame
// starts the unpacker, which reads the 22 channel bytes from the store one at a
// time, issuing each read only once the previous byte has arrived, and emits the
// 16 words, stalling while the output is held. While it runs, bytes of the next
// frame are taken as long as they land on entries already read; the closing byte
// waits until unpacking ends. Synchronous reset clears control and loads register
// defaults; the store is not cleared.
`default_nettype none
module sbus_frame_channel_decoder
  import sfd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  sfd_in_if.sink                in_ch,
  sfd_out_if.source             out_ch,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  cfg_t         cfg_r, cfg_nxt;
  store_wr_t    wr;
  logic         start;
  logic         rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]   rd_data;
  unpack_stat_t stat;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_HEADER:   cfg_nxt.header   = cfg_wdata[7:0];
        REG_DEADBAND: cfg_nxt.deadband = cfg_wdata;
        REG_SW_HIGH:  cfg_nxt.sw_high  = cfg_wdata;
        REG_SW_LOW:   cfg_nxt.sw_low   = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header   <= HEADER_RST;
      cfg_r.deadband <= DEADBAND_RST;
      cfg_r.sw_high  <= SW_HIGH_RST;
      cfg_r.sw_low   <= SW_LOW_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sfd_capture u_capture (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .header (cfg_r.header),
    .stat   (stat),
    .wr     (wr),
    .start  (start)
  );

  sfd_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sfd_unpack u_unpack (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .cfg     (cfg_r),
    .rd_data (rd_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .stat    (stat),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

### test/sbus_frame_channel_decoder_tb.sv
// Self-checking testbench for the SBUS frame channel decoder: byte stream in, channel words out.
`default_nettype none
module sbus_frame_channel_decoder_tb;
  import sfd_pkg::*;

  localparam int SETTLE_CYCLES   = 64;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT  = 4000;

  typedef struct {
    logic [IDX_W-1:0]   index;
    logic [CH_BITS-1:0] value;
    logic               last;
  } chan_word_t;

  typedef logic [NUM_CHANNELS-1:0][CH_BITS-1:0] raw_set_t;
  typedef logic [PAYLOAD_BYTES-1:0][7:0]        frame_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  cfg_reg_t         cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  sfd_in_if  in_ch ();
  sfd_out_if out_ch ();

  sbus_frame_channel_decoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // decoder image: registers, framing state and store
  logic [7:0]                 hdr_model;
  logic [CH_BITS-1:0]         deadband_model;
  logic [CH_BITS-1:0]         sw_high_model;
  logic [CH_BITS-1:0]         sw_low_model;
  logic                       framing;
  int                         rx_count;
  logic [STORE_DEPTH-1:0][7:0] rx_store;

  chan_word_t expected_chans[$];
  int         errors;
  bit         idling_on;
  bit         hold_off_req;

  initial begin : clock_gen
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic logic [CH_BITS-1:0] decode_channel(input int ch,
                                                        input logic [CH_BITS-1:0] raw);
    int centred;
    int mag;
    if (ch >= 4 && ch < 12) begin
      if (raw > sw_high_model) return SW_POS_UP;
      if (raw < sw_low_model) return SW_POS_DOWN;
      return SW_POS_MID;
    end
    centred = int'(raw) - int'(CENTRE);
    if (ch < 4) begin
      mag = (centred < 0) ? -centred : centred;
      if (mag < int'(deadband_model)) centred = 0;
    end
    return centred[CH_BITS-1:0];
  endfunction

  task automatic take_byte(input logic [7:0] b);
    logic [CHANNEL_BYTES*8-1:0] chan_bits;
    chan_word_t                 w;
    if (!framing) begin
      if (b == hdr_model) begin
        framing = 1'b1;
        rx_count = 0;
      end
      return;
    end
    rx_store[rx_count] = b;
    rx_count++;
    if (rx_count < PAYLOAD_BYTES) return;
    framing = 1'b0;
    rx_count = 0;
    chan_bits = rx_store[CHANNEL_BYTES-1:0];
    for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
      w.index = IDX_W'(ch);
      w.value = decode_channel(ch, chan_bits[ch*CH_BITS +: CH_BITS]);
      w.last  = (ch == NUM_CHANNELS - 1);
      expected_chans.push_back(w);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    take_byte(b);
  endtask

  task automatic send_frame(input frame_t fr);
    send_byte(hdr_model);
    for (int i = 0; i < PAYLOAD_BYTES; i++) send_byte(fr[i]);
  endtask

  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_chans.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_HEADER:   hdr_model      = val[7:0];
      REG_DEADBAND: deadband_model = val;
      REG_SW_HIGH:  sw_high_model  = val;
      REG_SW_LOW:   sw_low_model   = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [CFG_W-1:0] hdr, input logic [CFG_W-1:0] db,
                            input logic [CFG_W-1:0] hi, input logic [CFG_W-1:0] lo);
    write_reg(REG_HEADER, hdr);
    write_reg(REG_DEADBAND, db);
    write_reg(REG_SW_HIGH, hi);
    write_reg(REG_SW_LOW, lo);
  endtask

  function automatic frame_t make_frame(input raw_set_t raws, input logic [7:0] flag,
                                        input logic [7:0] footer);
    return {footer, flag, raws};
  endfunction

  // biased towards the switch thresholds and the deadband edges
  function automatic logic [CH_BITS-1:0] pick_raw();
    case ($urandom_range(0, 7))
      0: return CH_BITS'(sw_high_model + $urandom_range(0, 2) - 1);
      1: return CH_BITS'(sw_low_model + $urandom_range(0, 2) - 1);
      2: return CH_BITS'(CENTRE + deadband_model + $urandom_range(0, 2) - 1);
      3: return CH_BITS'(CENTRE - deadband_model + $urandom_range(0, 2) - 1);
      4: return ($urandom_range(0, 1) != 0) ? '1 : '0;
      default: return CH_BITS'($urandom_range(0, 2047));
    endcase
  endfunction

  function automatic frame_t random_frame();
    raw_set_t raws;
    for (int ch = 0; ch < NUM_CHANNELS; ch++) raws[ch] = pick_raw();
    return make_frame(raws, 8'($urandom), 8'($urandom));
  endfunction

  function automatic logic [CFG_W-1:0] rand_field(input int hi);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return CFG_W'(hi);
      default: return CFG_W'($urandom_range(0, hi));
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_default_frames();
    raw_set_t raws;
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(HEADER_RST - 8'd1);
    raws = '1;
    send_frame(make_frame(raws, HEADER_RST, HEADER_RST));
    settle();
  endtask

  task automatic test_deadband_and_switch_edges();
    raw_set_t raws;
    raws[0]  = 11'd1024;
    raws[1]  = 11'd1038;
    raws[2]  = 11'd1009;
    raws[3]  = 11'd1039;
    raws[4]  = 11'd1600;
    raws[5]  = 11'd1601;
    raws[6]  = 11'd400;
    raws[7]  = 11'd399;
    raws[8]  = 11'd0;
    raws[9]  = 11'd2047;
    raws[10] = 11'd1000;
    raws[11] = 11'd401;
    raws[12] = 11'd0;
    raws[13] = 11'd2047;
    raws[14] = 11'd1024;
    raws[15] = 11'd1;
    send_frame(make_frame(raws, 8'h00, 8'h00));
    settle();
  endtask

  task automatic test_register_extremes();
    raw_set_t raws;
    // wide deadband, crossed thresholds, header with bits above the byte
    set_config(11'h100, 11'h7ff, 11'd0, 11'h7ff);
    send_byte(8'hff);
    raws = '0;
    for (int ch = 3; ch < NUM_CHANNELS; ch++) raws[ch] = pick_raw();
    raws[0] = 11'd0;
    raws[1] = 11'd2047;
    raws[2] = 11'd1;
    send_frame(make_frame(raws, 8'h00, 8'hff));
    settle();
  endtask

  task automatic test_output_hold_off();
    idling_on = 1'b0;
    set_config(CFG_W'($urandom), rand_field(1024), rand_field(2047), rand_field(2047));
    hold_off_req = 1'b1;
    send_frame(random_frame());
    // next frame runs into the stalled unpacker
    send_byte(hdr_model);
    repeat (6) send_byte(8'($urandom));
    settle();
  endtask

  // ---------------------------------------------------------------- processes

  initial begin : stimulus
    errors         = 0;
    hdr_model      = HEADER_RST;
    deadband_model = DEADBAND_RST;
    sw_high_model  = SW_HIGH_RST;
    sw_low_model   = SW_LOW_RST;
    framing        = 1'b0;
    rx_count       = 0;
    rx_store       = '0;
    idling_on      = 1'b1;
    hold_off_req   = 1'b0;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.rx_byte  = 8'h00;
    cfg_we         = 1'b0;
    cfg_index      = REG_HEADER;
    cfg_wdata      = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_default_frames();
    test_deadband_and_switch_edges();
    test_register_extremes();
    test_output_hold_off();

    if (errors == 0) begin
      $display("sbus_frame_channel_decoder regression: pass");
    end else begin
      $display("sbus_frame_channel_decoder regression: fail");
    end
    $finish;
  end

  initial begin : word_sink
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        hold_off_req = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : chan_monitor
    chan_word_t w;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_chans.size() == 0) begin
        report_mismatch("unexpected word, channel", int'(out_ch.channel_index), -1);
      end else begin
        w = expected_chans.pop_front();
        if (out_ch.channel_index !== w.index)
          report_mismatch("channel_index", int'(out_ch.channel_index), int'(w.index));
        if (out_ch.channel_value !== $signed(w.value))
          report_mismatch($sformatf("channel_value ch %0d", w.index),
                          int'(out_ch.channel_value), int'($signed(w.value)));
        if (out_ch.last_of_frame !== w.last)
          report_mismatch($sformatf("last_of_frame ch %0d", w.index),
                          int'(out_ch.last_of_frame), int'(w.last));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("stalled: no word moved for %0d cycles, %0d words outstanding",
             WATCHDOG_LIMIT, expected_chans.size());
    $display("sbus_frame_channel_decoder regression: fail");
    $finish;
  end

endmodule
`default_nettype wire
